// ===== sv/gcnf_pkg.sv =====
// Shared types and constants for the grid cell neighbor finder.
// Holds status codes, register indexes, the neighbor offset table and the job record.
// No dependencies.
`timescale 1ns / 1ps

package gcnf_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_FOUND   = 2'd0;
    localparam status_t ST_OUTSIDE = 2'd1;
    localparam status_t ST_FAREDGE = 2'd2;
    localparam status_t ST_NONE    = 2'd3;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_INV_CELL_SIZE = 3'd0;
    localparam reg_idx_t REG_CELLS_X       = 3'd1;
    localparam reg_idx_t REG_CELLS_Y       = 3'd2;
    localparam reg_idx_t REG_CELLS_Z       = 3'd3;
    localparam reg_idx_t REG_RANGE_X       = 3'd4;
    localparam reg_idx_t REG_RANGE_Y       = 3'd5;
    localparam reg_idx_t REG_RANGE_Z       = 3'd6;

    localparam int NUM_NB  = 26;
    localparam int CELL_OW = 10;

    // Per-axis offset codes, two's complement in two bits.
    localparam logic [1:0] OM = 2'b11;
    localparam logic [1:0] OZ = 2'b00;
    localparam logic [1:0] OP = 2'b01;

    // {dx, dy, dz}: faces, then edges, then corners.
    localparam logic [5:0] NB_OFF [NUM_NB] = '{
        {OM, OZ, OZ}, {OP, OZ, OZ}, {OZ, OM, OZ}, {OZ, OP, OZ}, {OZ, OZ, OM}, {OZ, OZ, OP},
        {OZ, OM, OM}, {OZ, OM, OP}, {OZ, OP, OP}, {OZ, OP, OM},
        {OM, OZ, OM}, {OM, OZ, OP}, {OP, OZ, OM}, {OP, OZ, OP},
        {OM, OM, OZ}, {OM, OP, OZ}, {OP, OM, OZ}, {OP, OP, OZ},
        {OM, OM, OM}, {OM, OM, OP}, {OM, OP, OM}, {OM, OP, OP},
        {OP, OM, OM}, {OP, OM, OP}, {OP, OP, OM}, {OP, OP, OP}
    };

    typedef struct packed {
        logic                 list;
        status_t              status;
        logic [CELL_OW-1:0]   cx;
        logic [CELL_OW-1:0]   cy;
        logic [CELL_OW-1:0]   cz;
        logic [NUM_NB-1:0]    mask;
    } job_t;

    // lo[a]: a step down on axis a stays in the grid; hi[a]: a step up does.
    // Axis 2 is x, 1 is y, 0 is z, matching the code order in NB_OFF.
    function automatic logic [NUM_NB-1:0] nb_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [NUM_NB-1:0] m;
        logic [1:0]        c;
        m = '0;
        for (int i = 0; i < NUM_NB; i++) begin
            m[i] = 1'b1;
            for (int a = 0; a < 3; a++) begin
                c = NB_OFF[i][2*a +: 2];
                if (c == OM && !lo[a]) m[i] = 1'b0;
                if (c == OP && !hi[a]) m[i] = 1'b0;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/gcnf_axis.sv =====
// One axis of the cell locator: range test and reciprocal multiply, then index compare.
// Depends on gcnf_pkg.
`timescale 1ns / 1ps

module gcnf_axis #(
    parameter int MAX_CELLS_PER_AXIS = 1024,
    parameter int FRAC_BITS          = 16
) (
    input  logic                       aclk,
    input  logic                       load,
    input  logic signed [31:0]         pos,
    input  logic [30:0]                range_val,
    input  logic [23:0]                inv,
    input  logic [10:0]                cells,
    output gcnf_pkg::status_t          cls,
    output logic [gcnf_pkg::CELL_OW-1:0] cell_idx,
    output logic                       lo_ok,
    output logic                       hi_ok
);

    localparam int PROD_W  = 55;
    localparam int SHIFT   = 2 * FRAC_BITS;
    localparam int EFF_MAX = (MAX_CELLS_PER_AXIS < 2047) ? MAX_CELLS_PER_AXIS : 2047;
    localparam logic [10:0] EFF_MAX11 = 11'(EFF_MAX);

    logic              outside_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] idx;
    logic [10:0]       eff;

    always_ff @(posedge aclk) begin
        if (load) begin
            outside_reg <= pos[31] || (pos[30:0] > range_val);
            prod_reg    <= PROD_W'(pos[30:0]) * PROD_W'(inv);
        end
    end

    always_comb begin
        eff      = (cells > EFF_MAX11) ? EFF_MAX11 : cells;
        idx      = prod_reg >> SHIFT;
        cell_idx = idx[gcnf_pkg::CELL_OW-1:0];
        lo_ok    = (idx != '0);
        hi_ok    = ((idx + PROD_W'(1)) < PROD_W'(eff));
        priority if (outside_reg) begin
            cls = gcnf_pkg::ST_OUTSIDE;
        end else if (idx >= PROD_W'(eff)) begin
            cls = gcnf_pkg::ST_FAREDGE;
        end else begin
            cls = gcnf_pkg::ST_FOUND;
        end
    end

endmodule

// ===== sv/gcnf_emit.sv =====
// Result sequencer: holds one job, emits its results one per cycle unless stalled, into the output register.
// Depends on gcnf_pkg.
`timescale 1ns / 1ps

module gcnf_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    input  gcnf_pkg::job_t             job,
    output logic                       job_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gcnf_pkg::CELL_OW-1:0] m_cell_x,
    output logic [gcnf_pkg::CELL_OW-1:0] m_cell_y,
    output logic [gcnf_pkg::CELL_OW-1:0] m_cell_z,
    output gcnf_pkg::status_t          m_status,
    output logic                       m_last
);

    localparam int W = gcnf_pkg::CELL_OW;

    logic                        job_vld_reg;
    gcnf_pkg::job_t              job_reg;
    logic                        m_valid_reg;
    logic [W-1:0]                cx_reg, cy_reg, cz_reg;
    gcnf_pkg::status_t           st_reg;
    logic                        last_reg;

    logic                        out_free;
    logic                        emit;
    logic                        cur_last;
    logic [gcnf_pkg::NUM_NB-1:0] low;
    logic [gcnf_pkg::NUM_NB-1:0] rest;
    logic [5:0]                  off;
    logic [W-1:0]                qx, qy, qz;

    always_comb begin
        low = job_reg.mask & (~job_reg.mask + gcnf_pkg::NUM_NB'(1));
        rest = job_reg.mask & ~low;
        off = '0;
        for (int i = 0; i < gcnf_pkg::NUM_NB; i++) begin
            off = off | ({6{low[i]}} & gcnf_pkg::NB_OFF[i]);
        end
        qx = job_reg.cx + {{(W-2){off[5]}}, off[5:4]};
        qy = job_reg.cy + {{(W-2){off[3]}}, off[3:2]};
        qz = job_reg.cz + {{(W-2){off[1]}}, off[1:0]};
        cur_last  = !job_reg.list || (rest == '0);
        out_free  = !m_valid_reg || m_ready;
        emit      = job_vld_reg && out_free;
        job_ready = !job_vld_reg || (emit && cur_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (job_ready) begin
                job_vld_reg <= job_valid;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            job_reg <= job;
        end else if (emit) begin
            job_reg.mask <= rest;
        end
        if (emit) begin
            if (job_reg.list) begin
                cx_reg <= qx;
                cy_reg <= qy;
                cz_reg <= qz;
            end else begin
                cx_reg <= job_reg.cx;
                cy_reg <= job_reg.cy;
                cz_reg <= job_reg.cz;
            end
            st_reg   <= job_reg.status;
            last_reg <= cur_last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_cell_x = cx_reg;
    assign m_cell_y = cy_reg;
    assign m_cell_z = cz_reg;
    assign m_status = st_reg;
    assign m_last   = last_reg;

endmodule

// ===== sv/grid_cell_neighbor_finder.sv =====
// Top level of the uniform 3D grid cell locator and neighbor lister.
// Depends on gcnf_pkg, gcnf_axis and gcnf_emit.
`timescale 1ns / 1ps

// Each input item carries a signed Q15.16 position and an action. Action 0 returns
// the cell that holds the position; action 1 lists its in-grid neighbors among the
// 26 adjacent cells (faces, then edges, then corners), one result per cycle unless
// the result channel stalls, with m_last on the final one. A position outside the
// domain or past the last cell gives a single status result for either action, and
// a list with no neighbor gives one "no neighbors" status result. An item yields one
// result (locate or status) or n for a list of n neighbors (1 to 26); input items are
// taken back to back while the sequencer keeps up. An item passes the input register,
// per-axis multiply register, job register and output register to its first result.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this.

module grid_cell_neighbor_finder #(
    parameter int MAX_CELLS_PER_AXIS = 1024,
    parameter int FRAC_BITS          = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  gcnf_pkg::reg_idx_t   cfg_index,
    input  logic [30:0]          cfg_data,
    // input item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    // result item channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [9:0]           m_cell_x,
    output logic [9:0]           m_cell_y,
    output logic [9:0]           m_cell_z,
    output gcnf_pkg::status_t    m_status,
    output logic                 m_last
);

    // Configuration registers.
    logic [23:0] inv_reg;
    logic [10:0] cells_x_reg, cells_y_reg, cells_z_reg;
    logic [30:0] range_x_reg, range_y_reg, range_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg     <= 24'd65536;
            cells_x_reg <= 11'd1;
            cells_y_reg <= 11'd1;
            cells_z_reg <= 11'd1;
            range_x_reg <= 31'd65536;
            range_y_reg <= 31'd65536;
            range_z_reg <= 31'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gcnf_pkg::REG_INV_CELL_SIZE: inv_reg     <= cfg_data[23:0];
                gcnf_pkg::REG_CELLS_X:       cells_x_reg <= cfg_data[10:0];
                gcnf_pkg::REG_CELLS_Y:       cells_y_reg <= cfg_data[10:0];
                gcnf_pkg::REG_CELLS_Z:       cells_z_reg <= cfg_data[10:0];
                gcnf_pkg::REG_RANGE_X:       range_x_reg <= cfg_data;
                gcnf_pkg::REG_RANGE_Y:       range_y_reg <= cfg_data;
                gcnf_pkg::REG_RANGE_Z:       range_z_reg <= cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Pipeline control: each stage advances when the next one can take its item.
    logic v0_reg, v1_reg;
    logic r0, r1;
    logic job_ready;

    assign r1      = !v1_reg || job_ready;
    assign r0      = !v0_reg || r1;
    assign s_ready = r0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            if (r0) v0_reg <= s_valid;
            if (r1) v1_reg <= v0_reg;
        end
    end

    // Stage 0: input register.
    logic               act0_reg, act1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (r0 && s_valid) begin
            act0_reg <= s_action;
            px_reg   <= s_pos_x;
            py_reg   <= s_pos_y;
            pz_reg   <= s_pos_z;
        end
        if (r1 && v0_reg) begin
            act1_reg <= act0_reg;
        end
    end

    // Stage 1: per-axis range test and reciprocal multiply, registered inside each axis.
    logic                 load1;
    gcnf_pkg::status_t    cls_x, cls_y, cls_z;
    logic [9:0]           cx, cy, cz;
    logic [2:0]           lo_ok, hi_ok;

    assign load1 = r1 && v0_reg;

    gcnf_axis #(.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS), .FRAC_BITS(FRAC_BITS)) u_ax_x (
        .aclk(aclk), .load(load1), .pos(px_reg), .range_val(range_x_reg), .inv(inv_reg),
        .cells(cells_x_reg), .cls(cls_x), .cell_idx(cx), .lo_ok(lo_ok[2]), .hi_ok(hi_ok[2])
    );

    gcnf_axis #(.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS), .FRAC_BITS(FRAC_BITS)) u_ax_y (
        .aclk(aclk), .load(load1), .pos(py_reg), .range_val(range_y_reg), .inv(inv_reg),
        .cells(cells_y_reg), .cls(cls_y), .cell_idx(cy), .lo_ok(lo_ok[1]), .hi_ok(hi_ok[1])
    );

    gcnf_axis #(.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS), .FRAC_BITS(FRAC_BITS)) u_ax_z (
        .aclk(aclk), .load(load1), .pos(pz_reg), .range_val(range_z_reg), .inv(inv_reg),
        .cells(cells_z_reg), .cls(cls_z), .cell_idx(cz), .lo_ok(lo_ok[0]), .hi_ok(hi_ok[0])
    );

    // Merge axis results into one job: outside wins over far edge, then locate or list.
    gcnf_pkg::job_t           job;
    logic [gcnf_pkg::NUM_NB-1:0] nbm;

    always_comb begin
        nbm        = gcnf_pkg::nb_mask(lo_ok, hi_ok);
        job.list   = 1'b0;
        job.status = gcnf_pkg::ST_FOUND;
        job.cx     = '0;
        job.cy     = '0;
        job.cz     = '0;
        job.mask   = nbm;
        priority if (cls_x == gcnf_pkg::ST_OUTSIDE || cls_y == gcnf_pkg::ST_OUTSIDE ||
                     cls_z == gcnf_pkg::ST_OUTSIDE) begin
            job.status = gcnf_pkg::ST_OUTSIDE;
        end else if (cls_x == gcnf_pkg::ST_FAREDGE || cls_y == gcnf_pkg::ST_FAREDGE ||
                     cls_z == gcnf_pkg::ST_FAREDGE) begin
            job.status = gcnf_pkg::ST_FAREDGE;
        end else if (!act1_reg) begin
            job.cx = cx;
            job.cy = cy;
            job.cz = cz;
        end else if (nbm == '0) begin
            job.status = gcnf_pkg::ST_NONE;
        end else begin
            // hold the home cell; the sequencer adds one offset per result
            job.list = 1'b1;
            job.cx   = cx;
            job.cy   = cy;
            job.cz   = cz;
        end
    end

    // Stage 2 and 3: job register, result sequencer and output register.
    gcnf_emit u_emit (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(v1_reg), .job(job), .job_ready(job_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cell_x(m_cell_x), .m_cell_y(m_cell_y), .m_cell_z(m_cell_z),
        .m_status(m_status), .m_last(m_last)
    );

endmodule

// ===== sv/gcnf_checker.sv =====
// Port-level checks for the grid cell neighbor finder, bound to the top level.
// Depends on gcnf_pkg and grid_cell_neighbor_finder.
`timescale 1ns / 1ps

module gcnf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [9:0]        m_cell_x,
    input logic [9:0]        m_cell_y,
    input logic [9:0]        m_cell_z,
    input gcnf_pkg::status_t m_status,
    input logic              m_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_cell_x, m_cell_y, m_cell_z,
                                                    m_status, m_last}))
        else $error("stalled result changed");

    // A status result is alone for its item and carries no cell.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != gcnf_pkg::ST_FOUND |->
            m_last && m_cell_x == '0 && m_cell_y == '0 && m_cell_z == '0)
        else $error("status result malformed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind grid_cell_neighbor_finder gcnf_checker u_gcnf_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_cell_x(m_cell_x), .m_cell_y(m_cell_y), .m_cell_z(m_cell_z),
    .m_status(m_status), .m_last(m_last)
);

// ===== tb/sv/gcnf_cell_checker.sv =====
// Result checker for the grid cell neighbor finder: tracks the register file, predicts the
// cells each accepted item should produce and compares them in order with the result channel.
// Depends on gcnf_pkg for the status codes and register indexes.
`timescale 1ns / 1ps

module gcnf_cell_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  gcnf_pkg::reg_idx_t   cfg_index,
    input  logic [30:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_action,
    input  logic [31:0]          s_pos_x,
    input  logic [31:0]          s_pos_y,
    input  logic [31:0]          s_pos_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [9:0]           m_cell_x,
    input  logic [9:0]           m_cell_y,
    input  logic [9:0]           m_cell_z,
    input  gcnf_pkg::status_t    m_status,
    input  logic                 m_last,
    output int                   mismatch_count,
    output int                   cells_owed
);

    import gcnf_pkg::*;

    localparam int   GRID_CAP = 1024;
    localparam logic ACT_LIST = 1'b1;

    typedef struct packed {
        logic [9:0] cx;
        logic [9:0] cy;
        logic [9:0] cz;
        status_t    status;
        logic       last;
    } cell_result_t;

    cell_result_t cells_due[$];
    cell_result_t want;
    cell_result_t got;

    logic [23:0] inv_size;
    logic [10:0] cells_n [3];
    logic [30:0] extent [3];

    // Neighbor walk order: faces, then edges, then corners.
    int nb_dx [26] = '{-1, 1, 0, 0, 0, 0,  0, 0, 0, 0, -1, -1, 1, 1, -1, -1, 1, 1,
                       -1, -1, -1, -1, 1, 1, 1, 1};
    int nb_dy [26] = '{0, 0, -1, 1, 0, 0,  -1, -1, 1, 1, 0, 0, 0, 0, -1, 1, -1, 1,
                       -1, -1, 1, 1, -1, -1, 1, 1};
    int nb_dz [26] = '{0, 0, 0, 0, -1, 1,  -1, 1, 1, -1, -1, 1, -1, 1, 0, 0, 0, 0,
                       -1, 1, -1, 1, -1, 1, -1, 1};

    initial begin
        mismatch_count = 0;
        cells_owed     = 0;
    end

    function automatic int capped(input logic [10:0] n);
        return (n > GRID_CAP) ? GRID_CAP : int'(n);
    endfunction

    function automatic void locate_axis(input logic [31:0] p, input int a,
                                        output status_t st, output int idx);
        logic [55:0] prod;
        st  = ST_FOUND;
        idx = 0;
        if (p[31] || p[30:0] > extent[a]) begin
            st = ST_OUTSIDE;
        end else begin
            prod = 56'(p) * 56'(inv_size);
            if (prod[55:32] >= capped(cells_n[a])) st = ST_FAREDGE;
            else idx = int'(prod[55:32]);
        end
    endfunction

    function automatic void predict_cells(input logic act, input logic [31:0] px,
                                          input logic [31:0] py, input logic [31:0] pz);
        logic [31:0]  pos [3];
        status_t      st [3];
        int           home [3];
        int           q [3];
        status_t      verdict;
        cell_result_t r;
        int           found;
        bit           ok;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        for (int a = 0; a < 3; a++) locate_axis(pos[a], a, st[a], home[a]);
        // outside wins over far edge
        verdict = ST_FOUND;
        for (int a = 0; a < 3; a++) if (st[a] == ST_FAREDGE) verdict = ST_FAREDGE;
        for (int a = 0; a < 3; a++) if (st[a] == ST_OUTSIDE) verdict = ST_OUTSIDE;
        r = '0;
        r.last = 1'b1;
        if (verdict != ST_FOUND) begin
            r.status = verdict;
            cells_due = {cells_due, r};
        end else if (act != ACT_LIST) begin
            r.cx = 10'(home[0]);
            r.cy = 10'(home[1]);
            r.cz = 10'(home[2]);
            cells_due = {cells_due, r};
        end else begin
            found = 0;
            for (int i = 0; i < 26; i++) begin
                q[0] = home[0] + nb_dx[i];
                q[1] = home[1] + nb_dy[i];
                q[2] = home[2] + nb_dz[i];
                ok = 1'b1;
                for (int a = 0; a < 3; a++)
                    if (q[a] < 0 || q[a] >= capped(cells_n[a])) ok = 1'b0;
                if (ok) begin
                    r.cx   = 10'(q[0]);
                    r.cy   = 10'(q[1]);
                    r.cz   = 10'(q[2]);
                    r.last = 1'b0;
                    cells_due = {cells_due, r};
                    found++;
                end
            end
            if (found == 0) begin
                r        = '0;
                r.status = ST_NONE;
                r.last   = 1'b1;
                cells_due = {cells_due, r};
            end else begin
                cells_due[cells_due.size() - 1].last = 1'b1;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            inv_size = 24'd65536;
            for (int a = 0; a < 3; a++) begin
                cells_n[a] = 11'd1;
                extent[a]  = 31'd65536;
            end
            cells_due.delete();
        end else begin
            // results first: an item accepted at this edge cannot have produced one yet
            if (m_valid && m_ready) begin
                got.cx     = m_cell_x;
                got.cy     = m_cell_y;
                got.cz     = m_cell_z;
                got.status = m_status;
                got.last   = m_last;
                if (cells_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: cell %0d %0d %0d status %0d last %0d",
                                 got.cx, got.cy, got.cz, got.status, got.last);
                end else begin
                    want = cells_due.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
                        got.status !== want.status || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("result mismatch: expected cell %0d %0d %0d status %0d ",
                                   want.cx, want.cy, want.cz, want.status);
                            $write("last %0d, got cell %0d %0d %0d ",
                                   want.last, got.cx, got.cy, got.cz);
                            $display("status %0d last %0d", got.status, got.last);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_INV_CELL_SIZE: inv_size   = cfg_data[23:0];
                    REG_CELLS_X:       cells_n[0] = cfg_data[10:0];
                    REG_CELLS_Y:       cells_n[1] = cfg_data[10:0];
                    REG_CELLS_Z:       cells_n[2] = cfg_data[10:0];
                    REG_RANGE_X:       extent[0]  = cfg_data;
                    REG_RANGE_Y:       extent[1]  = cfg_data;
                    REG_RANGE_Z:       extent[2]  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_cells(s_action, s_pos_x, s_pos_y, s_pos_z);
        end
        cells_owed = cells_due.size();
    end

endmodule

// ===== tb/sv/tb_grid_cell_neighbor_finder.sv =====
// Top of the grid cell neighbor finder testbench: clock, reset, grid setup and query stimulus.
// Instantiates grid_cell_neighbor_finder and gcnf_cell_checker; depends on gcnf_pkg.
`timescale 1ns / 1ps

module tb_grid_cell_neighbor_finder;

    import gcnf_pkg::*;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_ITEMS   = 35;
    localparam int          RANDOM_PHASES = 7;
    localparam logic [31:0] ONE           = 32'd65536;   // 1.0 in Q15.16
    localparam logic [31:0] HALF          = 32'd32768;
    localparam logic        ACT_LOCATE    = 1'b0;
    localparam logic        ACT_LIST      = 1'b1;
    // index 7 is past the register list; the block must ignore writes to it
    localparam reg_idx_t    REG_SPARE     = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    reg_idx_t     cfg_index;
    logic [30:0]  cfg_data;
    logic         s_valid;
    logic         s_ready;
    logic         s_action;
    logic [31:0]  s_pos_x;
    logic [31:0]  s_pos_y;
    logic [31:0]  s_pos_z;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [9:0]   m_cell_x;
    logic [9:0]   m_cell_y;
    logic [9:0]   m_cell_z;
    status_t      m_status;
    logic         m_last;

    int           mismatch_count;
    int           cells_owed;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           rx_left = 0;
    rx_mode_t     rx_mode = RX_OPEN;

    // Grid as last written; used only to aim positions at cells and boundaries.
    logic [23:0]  cur_inv;
    logic [10:0]  cur_cells [3];
    logic [30:0]  cur_range [3];

    grid_cell_neighbor_finder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_pos_x   (s_pos_x),
        .s_pos_y   (s_pos_y),
        .s_pos_z   (s_pos_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_cell_x  (m_cell_x),
        .m_cell_y  (m_cell_y),
        .m_cell_z  (m_cell_z),
        .m_status  (m_status),
        .m_last    (m_last)
    );

    gcnf_cell_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_x       (m_cell_x),
        .m_cell_y       (m_cell_y),
        .m_cell_z       (m_cell_z),
        .m_status       (m_status),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .cells_owed     (cells_owed)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_grid_cell_neighbor_finder failed");
            $finish;
        end
    end

    // Result side backpressure: switch at random between stall patterns, including
    // open stretches with no stall at all.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready = 1'b1;
            RX_COIN:   m_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
            default:   m_ready = (rx_left % 5) != 0;
        endcase
    end

    function automatic int cap_cells(input logic [10:0] n);
        return (n > 11'd1024) ? 1024 : int'(n);
    endfunction

    // Smallest Q15.16 position that maps into cell k under the current reciprocal.
    function automatic longint unsigned cell_start(input int k);
        longint unsigned num;
        if (cur_inv == 0) return 0;
        num = k;
        num = (num << 32) + cur_inv - 1;
        return num / cur_inv;
    endfunction

    // Aim one coordinate: mostly inside the domain, often on a cell boundary or the
    // domain edges, sometimes just negative or just past the range. Noisy items get
    // fully random bit patterns half the time.
    function automatic logic [31:0] pick_coord(input int a, input bit noisy);
        int          r;
        longint      b;
        logic [31:0] p;
        r = $urandom_range(0, 99);
        if (noisy && r < 50) return $urandom();
        if (r < 50) begin
            p = (cur_range[a] == 0) ? 32'd0 : $urandom_range(0, cur_range[a]);
        end else if (r < 75) begin
            b = cell_start($urandom_range(0, cap_cells(cur_cells[a])));
            b = b + int'($urandom_range(0, 2)) - 1;
            if (b < 0) b = 0;
            if (b > longint'(cur_range[a]) + 1) b = cur_range[a];
            p = b[31:0];
        end else if (r < 85) begin
            p = ($urandom_range(0, 1) != 0) ? {1'b0, cur_range[a]} : 32'd0;
        end else if (r < 93) begin
            p = 32'($urandom_range(0, 3)) - 32'd2;
        end else begin
            p = {1'b0, cur_range[a]} + 32'($urandom_range(1, 1000));
        end
        return p;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Drop valid and hold until every predicted cell has come out, then let the
    // pipeline settle before touching the registers.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (cells_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_grid(input logic [30:0] inv, input logic [30:0] cx,
                              input logic [30:0] cy, input logic [30:0] cz,
                              input logic [30:0] rx, input logic [30:0] ry,
                              input logic [30:0] rz);
        drain_results();
        write_reg(REG_SPARE, 31'($urandom()));
        write_reg(REG_INV_CELL_SIZE, inv);
        write_reg(REG_CELLS_X, cx);
        write_reg(REG_CELLS_Y, cy);
        write_reg(REG_CELLS_Z, cz);
        write_reg(REG_RANGE_X, rx);
        write_reg(REG_RANGE_Y, ry);
        write_reg(REG_RANGE_Z, rz);
        cur_inv      = inv[23:0];
        cur_cells[0] = cx[10:0];
        cur_cells[1] = cy[10:0];
        cur_cells[2] = cz[10:0];
        cur_range[0] = rx;
        cur_range[1] = ry;
        cur_range[2] = rz;
    endtask

    // Present one query and hold it until accepted. Bursts of random length are
    // separated by random gaps; a quarter of the bursts follow with no gap.
    task automatic send_item(input logic act, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid  = 1'b1;
        s_action = act;
        s_pos_x  = px;
        s_pos_y  = py;
        s_pos_z  = pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Random grid: mostly a consistent one (range covers exactly the cell count),
    // sometimes an arbitrary range, a zero count or a count past the cap.
    task automatic random_grid();
        logic [30:0]     inv;
        logic [30:0]     n [3];
        logic [30:0]     rng [3];
        longint unsigned fit;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 15) inv = 31'($urandom_range(1, 255));
        else if (r < 30) inv = 31'($urandom_range(24'hF00000, 24'hFFFFFF));
        else inv = 31'($urandom_range(1 << 13, 1 << 19));
        for (int a = 0; a < 3; a++) begin
            r = $urandom_range(0, 99);
            if (r < 65) n[a] = 31'($urandom_range(1, 12));
            else if (r < 85) n[a] = 31'($urandom_range(13, 1024));
            else if (r < 90) n[a] = 31'd0;
            else if (r < 95) n[a] = 31'd1024;
            else n[a] = 31'($urandom_range(1025, 2047));
            r = $urandom_range(0, 99);
            if (r < 80) begin
                fit = cap_cells(n[a][10:0]);
                fit = ((fit << 32) + inv - 1) / inv;
                rng[a] = (fit > 64'h7FFFFFFF) ? 31'h7FFFFFFF : fit[30:0];
            end else begin
                rng[a] = 31'($urandom_range(0, 32'h7FFFFFFF));
            end
        end
        apply_grid(inv, n[0], n[1], n[2], rng[0], rng[1], rng[2]);
    endtask

    task automatic random_items(input int count);
        bit noisy;
        for (int i = 0; i < count; i++) begin
            noisy = ($urandom_range(0, 99) < 20);
            send_item(1'($urandom_range(0, 1)), pick_coord(0, noisy), pick_coord(1, noisy),
                      pick_coord(2, noisy));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_INV_CELL_SIZE;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_action  = ACT_LOCATE;
        s_pos_x   = '0;
        s_pos_y   = '0;
        s_pos_z   = '0;
        // stimulus copy of the reset register values
        cur_inv = 24'd65536;
        for (int a = 0; a < 3; a++) begin
            cur_cells[a] = 11'd1;
            cur_range[a] = 31'd65536;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset grid: a single unit cell, domain [0, 1.0] on each axis.
        send_item(ACT_LOCATE, 32'd0, 32'd0, 32'd0);
        send_item(ACT_LIST, 32'd0, 32'd0, 32'd0);              // lone cell: no neighbors
        send_item(ACT_LOCATE, HALF, HALF, HALF);
        send_item(ACT_LOCATE, ONE, 32'd0, 32'd0);              // exactly on the far edge
        send_item(ACT_LIST, 32'd0, ONE, 32'd0);
        send_item(ACT_LOCATE, 32'hFFFF_FFFF, 32'd0, 32'd0);    // just below zero
        send_item(ACT_LIST, 32'd0, 32'd0, 32'h8000_0000);      // most negative
        send_item(ACT_LOCATE, 32'h7FFF_FFFF, 32'd0, 32'd0);    // largest positive
        send_item(ACT_LOCATE, 32'd0, 32'd0, ONE + 1);          // just past the range

        // 8x8x8 grid of unit cells: interior, corners, an edge cell, the far edge and precedence.
        apply_grid(31'd65536, 31'd8, 31'd8, 31'd8, 31'd524288, 31'd524288, 31'd524288);
        send_item(ACT_LOCATE, 3 * ONE + HALF, 3 * ONE + HALF, 3 * ONE + HALF);
        send_item(ACT_LIST, 3 * ONE + HALF, 3 * ONE + HALF, 3 * ONE + HALF);
        send_item(ACT_LIST, 32'd0, 32'd0, 32'd0);
        send_item(ACT_LIST, 7 * ONE + 1, 7 * ONE + 1, 7 * ONE + 1);
        send_item(ACT_LIST, 32'd0, 3 * ONE + HALF, 7 * ONE + HALF);
        send_item(ACT_LOCATE, 8 * ONE, 32'd0, 32'd0);
        send_item(ACT_LIST, 8 * ONE + 1, 32'd0, 32'd0);
        send_item(ACT_LIST, 8 * ONE + 1, 8 * ONE, 32'd0);      // outside beats far edge

        // Extremes: full-width writes get masked, x count saturates, z has one cell.
        apply_grid(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1024, 31'd1,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(ACT_LOCATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_item(ACT_LIST, 32'(cell_start(1023)), 32'(cell_start(1023)), 32'd0);
        send_item(ACT_LIST, 32'(cell_start(1)), 32'(cell_start(1)), 32'd0);

        // Zero cells along x: nothing inside the domain maps to a cell.
        apply_grid(31'd65536, 31'd0, 31'd4, 31'd4, 31'(4 * ONE), 31'(4 * ONE), 31'(4 * ONE));
        send_item(ACT_LOCATE, ONE, ONE, ONE);
        send_item(ACT_LIST, 32'd0, 32'd0, 32'd0);
        send_item(ACT_LIST, 32'hFFFF_FFFB, ONE, ONE);

        // Empty domain with the smallest reciprocal.
        apply_grid(31'd1, 31'd1, 31'd1, 31'd1, 31'd0, 31'd0, 31'd0);
        send_item(ACT_LOCATE, 32'd0, 32'd0, 32'd0);
        send_item(ACT_LIST, 32'd0, 32'd0, 32'd0);
        send_item(ACT_LOCATE, 32'd1, 32'd0, 32'd0);

        // Random phases: a huge-cell grid first, then random grids.
        apply_grid(31'd1, 31'd3, 31'd1, 31'd2, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_items(PHASE_ITEMS);
        for (int ph = 1; ph < RANDOM_PHASES; ph++) begin
            random_grid();
            random_items(PHASE_ITEMS);
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("tb_grid_cell_neighbor_finder passed");
        end else begin
            $display("tb_grid_cell_neighbor_finder failed");
        end
        $finish;
    end

endmodule
